>>> design/sfv_pkg.sv
// Shared types and constants for the serial frame validator.
// No dependencies.
package sfv_pkg;

  localparam int MaxPayload = 256;
  localparam int MaxBuffer  = 255;
  localparam int HdrBytes   = 5;
  localparam int Overhead   = 7;
  localparam int PayAw      = $clog2(MaxPayload);
  localparam int StoreAw    = PayAw + 1;
  localparam int QDepth     = 2;

  localparam logic       CMD_PUSH    = 1'b0;
  localparam logic       CMD_READ    = 1'b1;
  localparam logic       KIND_VERDICT = 1'b0;
  localparam logic       KIND_READ    = 1'b1;
  localparam logic [1:0] ST_PASS   = 2'd0;
  localparam logic [1:0] ST_ERR    = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [1:0] ST_REPEAT = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [7:0]  function_code;
    logic [7:0]  transaction_id;
    logic [15:0] payload_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic [7:0]  read_byte;
  } out_word_t;

  // work handed from front to back
  typedef struct packed {
    logic               is_read;
    logic               rd_valid;    // read index within payload
    logic [StoreAw-1:0] rd_addr;
    logic               verdict;
    out_word_t          res;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] r, input logic [7:0] b);
    logic [15:0] v;
    v = r ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
    end
    return v;
  endfunction

endpackage

>>> design/sfv_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module sfv_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> design/sfv_front.sv
// Front end: parses frame bytes, runs the CRC, writes payload, forms verdicts.
// Depends on sfv_pkg.
module sfv_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sfv_pkg::in_word_t          in_data,
  input  logic [7:0]                 station_address,
  input  logic                       q_full,
  output logic                       q_push,
  output sfv_pkg::job_t              q_job,
  output logic                       st_we,
  output logic [sfv_pkg::StoreAw-1:0] st_waddr,
  output logic [7:0]                 st_wdata
);
  logic [7:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  addr_r, addr_nxt, func_r, func_nxt, tid_r, tid_nxt, last_tid_r, last_tid_nxt;
  logic [15:0] len_r, len_nxt, rcrc_r, rcrc_nxt;
  logic        bank_r, bank_nxt;

  logic        acc, push, rd, counted;
  logic [16:0] crc_end, pos;
  logic [16:0] p;
  logic [15:0] comp;
  logic [1:0]  st;

  assign in_stall = q_full;
  assign acc  = in_valid && !q_full;
  assign rd   = (in_data.cmd == sfv_pkg::CMD_READ);
  assign push = acc && !rd;
  assign counted = cnt_r < 8'(sfv_pkg::MaxBuffer);
  assign pos     = {9'd0, cnt_r};
  assign crc_end = {1'b0, len_r} + 17'(sfv_pkg::HdrBytes);
  assign p       = pos - 17'(sfv_pkg::HdrBytes);

  always_comb begin
    cnt_nxt = cnt_r; crc_nxt = crc_r; addr_nxt = addr_r; func_nxt = func_r;
    tid_nxt = tid_r; len_nxt = len_r; rcrc_nxt = rcrc_r;
    last_tid_nxt = last_tid_r; bank_nxt = bank_r;
    st_we = 1'b0;
    st_waddr = {~bank_r, p[sfv_pkg::PayAw-1:0]};
    st_wdata = in_data.data_byte;
    if (push && counted) begin
      unique case (cnt_r)
        8'd0: addr_nxt = in_data.data_byte;
        8'd1: func_nxt = in_data.data_byte;
        8'd2: tid_nxt  = in_data.data_byte;
        8'd3: len_nxt  = {in_data.data_byte, len_r[7:0]};
        8'd4: len_nxt  = {len_r[15:8], in_data.data_byte};
        default: ;
      endcase
      if (pos < 17'(sfv_pkg::HdrBytes) || pos < crc_end)
        crc_nxt = sfv_pkg::crc_feed(crc_r, in_data.data_byte);
      if (pos >= 17'(sfv_pkg::HdrBytes) && pos < crc_end && p < 17'(sfv_pkg::MaxPayload))
        st_we = 1'b1;
      if (pos >= 17'(sfv_pkg::HdrBytes)) begin
        if (pos == crc_end) rcrc_nxt = {in_data.data_byte, rcrc_r[7:0]};
        else if (pos == crc_end + 17'd1) rcrc_nxt = {rcrc_r[15:8], in_data.data_byte};
      end
      cnt_nxt = cnt_r + 8'd1;
    end
    // verdict uses the updated frame state
    comp = {crc_nxt[7:0], crc_nxt[15:8]};
    priority if (addr_nxt != station_address) st = sfv_pkg::ST_ERR;
    else if ({1'b0, len_nxt} + 17'(sfv_pkg::Overhead) > {9'd0, cnt_nxt}) st = sfv_pkg::ST_SHORT;
    else if (tid_nxt == last_tid_r) st = sfv_pkg::ST_REPEAT;
    else if (comp == rcrc_nxt) st = sfv_pkg::ST_PASS;
    else st = sfv_pkg::ST_ERR;
    if (push && in_data.last_byte) begin
      if (st == sfv_pkg::ST_PASS) begin
        last_tid_nxt = tid_nxt;
        bank_nxt = ~bank_r;
      end
      cnt_nxt = '0; crc_nxt = 16'hFFFF; addr_nxt = '0; func_nxt = '0;
      tid_nxt = '0; len_nxt = '0; rcrc_nxt = '0;
    end
  end

  always_comb begin
    q_push = acc && (rd || in_data.last_byte);
    q_job = '0;
    q_job.is_read  = rd;
    q_job.rd_valid = {1'b0, in_data.read_index} < 9'(sfv_pkg::MaxPayload);
    q_job.rd_addr  = {bank_r, in_data.read_index[sfv_pkg::PayAw-1:0]};
    q_job.verdict  = !rd;
    if (rd) begin
      q_job.res.result_kind = sfv_pkg::KIND_READ;
    end else begin
      q_job.res.result_kind    = sfv_pkg::KIND_VERDICT;
      q_job.res.status         = st;
      q_job.res.function_code  = (push && counted && cnt_r == 8'd1) ? in_data.data_byte : func_r;
      q_job.res.transaction_id = (push && counted && cnt_r == 8'd2) ? in_data.data_byte : tid_r;
      q_job.res.payload_length = (push && counted && cnt_r == 8'd3) ?
                                 {in_data.data_byte, len_r[7:0]} :
                                 (push && counted && cnt_r == 8'd4) ?
                                 {len_r[15:8], in_data.data_byte} : len_r;
      q_job.res.crc_received   = (push && counted && pos >= 17'(sfv_pkg::HdrBytes)
                                  && pos == crc_end) ? {in_data.data_byte, rcrc_r[7:0]} :
                                 (push && counted && pos >= 17'(sfv_pkg::HdrBytes)
                                  && pos == crc_end + 17'd1) ?
                                 {rcrc_r[15:8], in_data.data_byte} : rcrc_r;
      q_job.res.crc_computed   = comp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; crc_r <= 16'hFFFF; addr_r <= '0; func_r <= '0; tid_r <= '0;
      len_r <= '0; rcrc_r <= '0; last_tid_r <= '0; bank_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; crc_r <= crc_nxt; addr_r <= addr_nxt; func_r <= func_nxt;
      tid_r <= tid_nxt; len_r <= len_nxt; rcrc_r <= rcrc_nxt;
      last_tid_r <= last_tid_nxt; bank_r <= bank_nxt;
    end
  end
endmodule

>>> design/sfv_back.sv
// Back end: job queue, payload store read and output register.
// Depends on sfv_pkg and sfv_ram.
module sfv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_push,
  input  sfv_pkg::job_t               q_job,
  output logic                        q_full,
  input  logic                        st_we,
  input  logic [sfv_pkg::StoreAw-1:0] st_waddr,
  input  logic [7:0]                  st_wdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sfv_pkg::out_word_t          out_data
);
  localparam int QAw = $clog2(sfv_pkg::QDepth);

  sfv_pkg::job_t q_mem_r [sfv_pkg::QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r, cnt_nxt;
  logic           pop, s1_valid_r, s1_rdv_r, out_free;
  sfv_pkg::out_word_t s1_res_r;
  sfv_pkg::out_word_t out_word_nxt;
  logic [7:0]     rdata;
  sfv_pkg::job_t  head;

  assign head   = q_mem_r[rp_r];
  assign q_full = cnt_r == (QAw+1)'(sfv_pkg::QDepth);
  // stage 1 holds the job while the RAM read is in flight
  assign out_free = !out_valid || !out_stall;
  assign pop = (cnt_r != '0) && (!s1_valid_r || out_free);

  always_comb begin
    cnt_nxt = cnt_r + (QAw+1)'(q_push) - (QAw+1)'(pop);
  end

  always_comb begin
    out_word_nxt = s1_res_r;
    if (s1_rdv_r) out_word_nxt.read_byte = rdata;
  end

  sfv_ram #(.Width(8), .Depth(2 * sfv_pkg::MaxPayload)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(pop), .raddr(head.rd_addr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (q_push) q_mem_r[wp_r] <= q_job;
    if (pop) begin
      s1_res_r <= head.res;
      s1_rdv_r <= head.is_read && head.rd_valid;
    end
    if (s1_valid_r && out_free) out_data <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; s1_valid_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (q_push) wp_r <= wp_r + QAw'(1);
      if (pop) rp_r <= rp_r + QAw'(1);
      cnt_r <= cnt_nxt;
      if (pop) s1_valid_r <= 1'b1;
      else if (out_free) s1_valid_r <= 1'b0;
      if (out_free) out_valid <= s1_valid_r;
    end
  end
endmodule

>>> design/serial_frame_validator_core.sv
// Serial frame validator: Modbus-style frame check with CRC-16 and payload store.
// Depends on sfv_pkg, sfv_front, sfv_back, sfv_ram.
//
// Input channel (in_valid/in_stall/in_data): one word per cycle unless stalled,
// either a received byte (cmd 0) or a read of the committed payload (cmd 1).
// A byte without the last mark gives no result; a last byte gives a verdict
// word, a read gives one data word, on out_valid/out_stall/out_data.
// Throughput is one word per cycle while in_stall is low; the CRC update and
// payload write happen in the accept cycle. The job is queued at the accept
// edge, the payload RAM is read as the job moves into stage 1, and the output
// register then loads and raises out_valid; out_stall can hold either step.
// A two-entry job queue sits between front and back; when out_stall holds,
// the queue fills and in_stall rises once it is full.
// cfg_valid/cfg_ready write station_address; cfg_ready is always high and
// writes belong in idle periods only.
// Reset (rst_n low, synchronous) clears frame state, the last accepted
// transaction id, the committed bank and the queue; station_address goes to 1.
// Payload entries never written read as undefined.
module serial_frame_validator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfv_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfv_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  logic [7:0] station_r;
  logic q_full, q_push, st_we;
  sfv_pkg::job_t q_job;
  logic [sfv_pkg::StoreAw-1:0] st_waddr;
  logic [7:0] st_wdata;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) station_r <= 8'd1;
    else if (cfg_valid) station_r <= cfg_data;
  end

  sfv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .station_address(station_r), .q_full(q_full),
    .q_push(q_push), .q_job(q_job), .st_we(st_we), .st_waddr(st_waddr),
    .st_wdata(st_wdata)
  );

  sfv_back u_back (
    .clk(clk), .rst_n(rst_n), .q_push(q_push), .q_job(q_job), .q_full(q_full),
    .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

>>> sim/tb_serial_frame_validator_core.sv
// Testbench for serial_frame_validator_core: frame verdicts and committed payload reads,
// checked against a behavioral predictor with random stalls. Depends on sfv_pkg.
module tb_serial_frame_validator_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sfv_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sfv_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  serial_frame_validator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  station;
  logic [7:0]  nbytes;
  logic [15:0] crc_reg;
  logic [7:0]  h_addr, h_func, h_tid, last_tid;
  logic [15:0] h_len, h_crc;
  logic [7:0]  bank_mem [0:2*sfv_pkg::MaxPayload-1];
  bit          written [0:2*sfv_pkg::MaxPayload-1];
  logic        bank;

  sfv_pkg::out_word_t expected_q[$];
  int errors = 0;
  int idle_pct = 29;
  bit rx_hold = 1'b0;
  int quiet = 0;

  // bytes of the frame being built
  logic [7:0] fb[$];

  function automatic logic [15:0] crc_step(logic [15:0] r, logic [7:0] b);
    logic [15:0] v;
    v = r ^ {8'h00, b};
    for (int k = 0; k < 8; k++) v = v[0] ? ((v >> 1) ^ 16'hA001) : (v >> 1);
    return v;
  endfunction

  function automatic void frame_reset();
    nbytes = 0; crc_reg = 16'hFFFF; h_addr = 0; h_func = 0; h_tid = 0;
    h_len = 0; h_crc = 0;
  endfunction

  function automatic void predict(sfv_pkg::in_word_t w);
    sfv_pkg::out_word_t r;
    int unsigned pos, cend;
    logic [15:0] comp;
    r = '0;
    if (w.cmd == sfv_pkg::CMD_READ) begin
      r.result_kind = sfv_pkg::KIND_READ;
      r.read_byte = bank_mem[{bank, w.read_index}];
      expected_q.push_back(r);
      return;
    end
    if (nbytes < sfv_pkg::MaxBuffer) begin
      pos = nbytes;
      cend = h_len + sfv_pkg::HdrBytes;
      case (pos)
        0: h_addr = w.data_byte;
        1: h_func = w.data_byte;
        2: h_tid = w.data_byte;
        3: h_len[15:8] = w.data_byte;
        4: h_len[7:0] = w.data_byte;
        default: ;
      endcase
      if (pos < sfv_pkg::HdrBytes || pos < cend) crc_reg = crc_step(crc_reg, w.data_byte);
      if (pos >= sfv_pkg::HdrBytes && pos < cend &&
          pos - sfv_pkg::HdrBytes < sfv_pkg::MaxPayload) begin
        bank_mem[{~bank, 8'(pos - sfv_pkg::HdrBytes)}] = w.data_byte;
        written[{~bank, 8'(pos - sfv_pkg::HdrBytes)}] = 1'b1;
      end
      if (pos >= sfv_pkg::HdrBytes) begin
        if (pos == cend) h_crc[15:8] = w.data_byte;
        else if (pos == cend + 1) h_crc[7:0] = w.data_byte;
      end
      nbytes++;
    end
    if (!w.last_byte) return;
    comp = {crc_reg[7:0], crc_reg[15:8]};
    if (h_addr != station) r.status = sfv_pkg::ST_ERR;
    else if (32'(h_len) + sfv_pkg::Overhead > 32'(nbytes)) r.status = sfv_pkg::ST_SHORT;
    else if (h_tid == last_tid) r.status = sfv_pkg::ST_REPEAT;
    else if (comp == h_crc) r.status = sfv_pkg::ST_PASS;
    else r.status = sfv_pkg::ST_ERR;
    if (r.status == sfv_pkg::ST_PASS) begin
      last_tid = h_tid;
      bank = ~bank;
    end
    r.result_kind = sfv_pkg::KIND_VERDICT;
    r.function_code = h_func;
    r.transaction_id = h_tid;
    r.payload_length = h_len;
    r.crc_received = h_crc;
    r.crc_computed = comp;
    expected_q.push_back(r);
    frame_reset();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report_mismatch("unexpected word", out_data[31:0], 0);
      else begin
        sfv_pkg::out_word_t e;
        e = expected_q.pop_front();
        if (out_data.result_kind !== e.result_kind)
          report_mismatch("result_kind", out_data.result_kind, e.result_kind);
        if (out_data.status !== e.status) report_mismatch("status", out_data.status, e.status);
        if (out_data.function_code !== e.function_code)
          report_mismatch("function_code", out_data.function_code, e.function_code);
        if (out_data.transaction_id !== e.transaction_id)
          report_mismatch("transaction_id", out_data.transaction_id, e.transaction_id);
        if (out_data.payload_length !== e.payload_length)
          report_mismatch("payload_length", out_data.payload_length, e.payload_length);
        if (out_data.crc_received !== e.crc_received)
          report_mismatch("crc_received", out_data.crc_received, e.crc_received);
        if (out_data.crc_computed !== e.crc_computed)
          report_mismatch("crc_computed", out_data.crc_computed, e.crc_computed);
        if (out_data.read_byte !== e.read_byte)
          report_mismatch("read_byte", out_data.read_byte, e.read_byte);
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < idle_pct);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sends one word, leaves valid high; idle gaps drop it first
  task automatic send_word(sfv_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(w);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    sfv_pkg::in_word_t w;
    w.cmd = sfv_pkg::CMD_PUSH; w.data_byte = b; w.last_byte = last;
    w.read_index = 8'($urandom);
    send_word(w);
  endtask

  task automatic read_payload(logic [7:0] idx);
    sfv_pkg::in_word_t w;
    w.cmd = sfv_pkg::CMD_READ; w.data_byte = 8'($urandom); w.last_byte = 1'($urandom);
    w.read_index = idx;
    send_word(w);
  endtask

  // builds a well formed frame in fb
  task automatic build_frame(logic [7:0] addr, logic [7:0] tid, int len);
    logic [15:0] c;
    fb.delete();
    fb.push_back(addr); fb.push_back(8'($urandom)); fb.push_back(tid);
    fb.push_back(8'(len >> 8)); fb.push_back(8'(len));
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (fb[i]) c = crc_step(c, fb[i]);
    fb.push_back(c[7:0]); fb.push_back(c[15:8]);
  endtask

  task automatic send_frame();
    foreach (fb[i]) push_byte(fb[i], i == fb.size() - 1);
  endtask

  // reads only entries some frame has written
  task automatic read_known();
    logic [7:0] idx;
    idx = 8'($urandom);
    if (written[{bank, idx}]) read_payload(idx);
    else if (written[{bank, 8'd0}]) read_payload(8'd0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_station(logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    station = a;
  endtask

  logic [7:0] next_tid = 8'd1;

  function automatic logic [7:0] fresh_tid();
    next_tid = next_tid + 8'd1;
    if (next_tid == last_tid) next_tid = next_tid + 8'd1;
    return next_tid;
  endfunction

  task automatic test_good_frames();
    build_frame(station, 8'd5, 0); send_frame();
    build_frame(station, 8'd5, 3); send_frame();   // repeated transaction
    build_frame(station, 8'd6, 248); send_frame(); // largest payload that fits the buffer
    read_payload(8'd0); read_payload(8'd247);
    build_frame(station, 8'd0, 1); send_frame();
    drain();
  endtask

  task automatic test_error_cases();
    // address mismatch, then crc corruption, then short frame
    build_frame(station ^ 8'h80, fresh_tid(), 2); send_frame();
    build_frame(station, fresh_tid(), 4); fb[6] = ~fb[6]; send_frame();
    build_frame(station, fresh_tid(), 10); fb = fb[0:8]; fb[8] = fb[8]; send_frame();
    push_byte(station, 1'b1);                       // single byte frame
    build_frame(station, fresh_tid(), 1);
    fb.push_back(8'hAA); fb.push_back(8'h55); send_frame(); // trailing bytes
    // overflow: 300 bytes, length field random
    for (int i = 0; i < 300; i++) push_byte(i == 0 ? station : 8'($urandom), i == 299);
    drain();
  endtask

  task automatic test_station_config();
    logic [7:0] vals[4] = '{8'h00, 8'hFF, 8'h5A, 8'h01};
    foreach (vals[k]) begin
      write_station(vals[k]);
      build_frame(vals[k], fresh_tid(), 3); send_frame();
      read_known();
      drain();
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    rx_hold = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) read_known();
    join
    drain();
    idle_pct = 29;
  endtask

  task automatic test_random_traffic();
    int n;
    int len;
    n = 0;
    while (n < 300) begin
      if (n > 60 && n < 180) idle_pct = 0; else idle_pct = 29;
      case ($urandom_range(9))
        0: begin
          push_byte(8'($urandom), 1'($urandom_range(3) == 0)); n++;
        end
        1, 2: begin
          read_known(); n++;
        end
        3: begin
          build_frame($urandom_range(3) == 0 ? 8'($urandom) : station, 8'($urandom),
                      $urandom_range(6));
          if (fb.size() > 3) fb[$urandom_range(fb.size() - 1)] ^= 8'(1 << $urandom_range(7));
          send_frame(); n += fb.size();
        end
        default: begin
          len = ($urandom_range(15) == 0) ? $urandom_range(248) : $urandom_range(12);
          build_frame(station, fresh_tid(), len);
          send_frame(); n += fb.size();
        end
      endcase
    end
    drain();
  endtask

  initial begin
    station = 8'd1; last_tid = 0; bank = 1'b0;
    for (int i = 0; i < 2 * sfv_pkg::MaxPayload; i++) begin
      bank_mem[i] = 8'h00;
      written[i] = 1'b0;
    end
    frame_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_frames();
    test_error_cases();
    test_station_config();
    test_backpressure();
    test_random_traffic();
    write_station(8'($urandom));
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> files.f
design/sfv_pkg.sv
design/sfv_ram.sv
design/sfv_front.sv
design/sfv_back.sv
design/serial_frame_validator_core.sv
sim/tb_serial_frame_validator_core.sv
